// ===== hdl/ffa_pkg.sv =====
// ============================================================================
// First-fit free-list allocator package
// Arena geometry, index and size widths, and the sequencer states.
// ============================================================================
`default_nettype none

package ffa_pkg;

  localparam int ARENA_BYTES  = 1024;
  localparam int HEADER_BYTES = 16;
  localparam int UNITS        = ARENA_BYTES / HEADER_BYTES;
  localparam int UNIT_W       = $clog2(UNITS);
  localparam int IDX_W        = UNIT_W + 1;
  localparam int SIZE_W       = $clog2(2 * ARENA_BYTES);
  localparam int HDR_SHIFT    = $clog2(HEADER_BYTES);
  localparam int OFF_W        = 10;
  localparam int REQ_W        = 10;
  localparam int LG_W         = 3;
  localparam int SUM_W        = SIZE_W + 1;
  localparam int PAD_W        = 7;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(UNITS);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_A_FIT,
    ST_A_LINK,
    ST_F_INS1,
    ST_F_INS2,
    ST_F_RDN,
    ST_F_CHKN,
    ST_F_CHKN2,
    ST_F_RDP,
    ST_F_CHKP,
    ST_DONE
  } state_t;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    clamp_idx = (v >= NIL) ? NIL : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/first_fit_free_list_allocator_unit.sv =====
// ============================================================================
// First-fit free-list allocator unit
// Address-ordered free list over one arena, with split on allocate and
// coalescing of neighbors on free, walked one node per cycle.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready) carries one item: action 0
//   allocates request_size bytes with the block end aligned to
//   2**align_log2 (at least 16), action 1 frees the block at free_offset.
//   The output channel (out_valid/out_ready) returns one item per input:
//   granted and, for a successful allocation, the payload offset.
//   The list walk visits one free node per cycle through the registered
//   read port of the header memories; a walk reads at most 64 list nodes.
//   A refused item (bad padding, bad free offset) skips the walk and goes
//   from idle straight to the done state.
//   One item is in work at a time; in_ready is high only while idle.
//   After reset the block writes the initial arena header in its init
//   state, then accepts items. The result sits in an output register:
//   the block takes the next item while the result waits, but does not
//   finish that item until the receiver has taken the earlier one.
// ============================================================================
`default_nettype none

module first_fit_free_list_allocator_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      action,
  input  wire logic [ffa_pkg::REQ_W-1:0] request_size,
  input  wire logic [ffa_pkg::LG_W-1:0]  align_log2,
  input  wire logic [ffa_pkg::OFF_W-1:0] free_offset,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           granted,
  output logic [ffa_pkg::OFF_W-1:0]      block_offset
);

  import ffa_pkg::*;

  logic [SIZE_W-1:0] size_mem [UNITS];
  logic [IDX_W-1:0]  link_mem [UNITS];
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  rd_link;
  logic [UNIT_W-1:0] rd_addr;

  logic              size_we;
  logic [UNIT_W-1:0] size_wa;
  logic [SIZE_W-1:0] size_wd;
  logic              link_we;
  logic [UNIT_W-1:0] link_wa;
  logic [IDX_W-1:0]  link_wd;

  state_t            state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic              op_free, op_free_next;
  logic [UNIT_W-1:0] node, node_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W-1:0]  prev, prev_next;
  logic [UNIT_W-1:0] steps, steps_next;
  logic [SIZE_W-1:0] wanted, wanted_next;
  logic [SIZE_W-1:0] grant_size, grant_size_next;
  logic [IDX_W-1:0]  after, after_next;
  logic [SIZE_W-1:0] node_size, node_size_next;
  logic [IDX_W-1:0]  node_link, node_link_next;
  logic              res_granted, res_granted_next;
  logic [OFF_W-1:0]  res_offset, res_offset_next;
  logic              out_load;

  logic [SIZE_W-1:0] req_sum;
  logic [PAD_W-1:0]  pad_mask;
  logic [PAD_W-1:0]  pad;
  logic              off_ok;
  logic [IDX_W-1:0]  rd_link_c;
  logic [IDX_W-1:0]  head_c;
  logic [SUM_W-1:0]  need;
  logic [SUM_W-1:0]  stepb;
  logic [IDX_W:0]    split_unit;
  logic [SUM_W-1:0]  node_end;
  logic [SUM_W-1:0]  prev_end;

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_size <= size_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

  assign req_sum    = SIZE_W'(HEADER_BYTES) + SIZE_W'(request_size);
  assign pad_mask   = (align_log2 < LG_W'(HDR_SHIFT)) ? PAD_W'(HEADER_BYTES - 1)
                    : PAD_W'((8'd1 << align_log2) - 8'd1);
  assign pad        = PAD_W'(SIZE_W'(0) - req_sum) & pad_mask;
  assign off_ok     = (free_offset[HDR_SHIFT-1:0] == '0) &&
                      (free_offset[OFF_W-1:HDR_SHIFT] != '0);
  assign rd_link_c  = clamp_idx(rd_link);
  assign head_c     = clamp_idx(head);
  assign need       = SUM_W'(wanted) + SUM_W'(HEADER_BYTES + 1);
  assign stepb      = SUM_W'(wanted) + SUM_W'(HEADER_BYTES);
  assign split_unit = (IDX_W + 1)'(cur) + (IDX_W + 1)'(stepb >> HDR_SHIFT);
  assign node_end   = (SUM_W'(node) << HDR_SHIFT) + SUM_W'(HEADER_BYTES) +
                      SUM_W'(node_size);
  assign prev_end   = (SUM_W'(prev) << HDR_SHIFT) + SUM_W'(HEADER_BYTES) +
                      SUM_W'(rd_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_free     <= op_free_next;
    node        <= node_next;
    cur         <= cur_next;
    prev        <= prev_next;
    steps       <= steps_next;
    wanted      <= wanted_next;
    grant_size  <= grant_size_next;
    after       <= after_next;
    node_size   <= node_size_next;
    node_link   <= node_link_next;
    res_granted <= res_granted_next;
    res_offset  <= res_offset_next;
    if (out_load) begin
      granted      <= res_granted;
      block_offset <= res_offset;
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    op_free_next     = op_free;
    node_next        = node;
    cur_next         = cur;
    prev_next        = prev;
    steps_next       = steps;
    wanted_next      = wanted;
    grant_size_next  = grant_size;
    after_next       = after;
    node_size_next   = node_size;
    node_link_next   = node_link;
    res_granted_next = res_granted;
    res_offset_next  = res_offset;
    rd_addr          = cur[UNIT_W-1:0];
    size_we          = 1'b0;
    size_wa          = '0;
    size_wd          = '0;
    link_we          = 1'b0;
    link_wa          = '0;
    link_wd          = '0;
    in_ready         = 1'b0;
    out_load         = 1'b0;

    unique case (state)
      ST_INIT: begin
        size_we    = 1'b1;
        size_wd    = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
        link_we    = 1'b1;
        link_wd    = NIL;
        head_next  = '0;
        state_next = ST_IDLE;
      end

      ST_IDLE: begin
        in_ready         = 1'b1;
        rd_addr          = head_c[UNIT_W-1:0];
        cur_next         = head_c;
        prev_next        = NIL;
        steps_next       = '0;
        op_free_next     = (action == ACT_FREE);
        wanted_next      = SIZE_W'(request_size) + SIZE_W'(pad);
        node_next        = UNIT_W'(free_offset[OFF_W-1:HDR_SHIFT] - 1'b1);
        res_granted_next = 1'b0;
        res_offset_next  = '0;
        if (in_valid) begin
          if (action == ACT_ALLOC) begin
            state_next = (pad > PAD_W'(HEADER_BYTES)) ? ST_DONE : ST_WALK;
          end else begin
            state_next = off_ok ? ST_WALK : ST_DONE;
          end
        end
      end

      ST_WALK: begin
        if (!op_free) begin
          if (cur == NIL) begin
            state_next = ST_DONE;
          end else if (wanted > rd_size) begin
            if (steps == UNIT_W'(UNITS - 1)) begin
              state_next = ST_DONE;
            end else begin
              steps_next = steps + 1'b1;
              prev_next  = cur;
              cur_next   = rd_link_c;
              rd_addr    = rd_link_c[UNIT_W-1:0];
            end
          end else begin
            state_next = ST_A_FIT;
          end
        end else begin
          if (cur == NIL || IDX_W'(node) < cur) begin
            state_next = ST_F_INS1;
          end else if (steps == UNIT_W'(UNITS - 1)) begin
            cur_next   = NIL;
            state_next = ST_F_INS1;
          end else begin
            steps_next = steps + 1'b1;
            prev_next  = cur;
            cur_next   = rd_link_c;
            rd_addr    = rd_link_c[UNIT_W-1:0];
          end
        end
      end

      ST_A_FIT: begin
        if (SUM_W'(rd_size) >= need && split_unit < (IDX_W + 1)'(UNITS)) begin
          size_we         = 1'b1;
          size_wa         = split_unit[UNIT_W-1:0];
          size_wd         = rd_size - stepb[SIZE_W-1:0];
          link_we         = 1'b1;
          link_wa         = split_unit[UNIT_W-1:0];
          link_wd         = rd_link_c;
          after_next      = split_unit[IDX_W-1:0];
          grant_size_next = wanted;
        end else begin
          after_next      = rd_link_c;
          grant_size_next = rd_size;
        end
        state_next = ST_A_LINK;
      end

      ST_A_LINK: begin
        if (prev == NIL) begin
          head_next = after;
        end else begin
          link_we = 1'b1;
          link_wa = prev[UNIT_W-1:0];
          link_wd = after;
        end
        size_we          = 1'b1;
        size_wa          = cur[UNIT_W-1:0];
        size_wd          = grant_size;
        res_granted_next = 1'b1;
        res_offset_next  = OFF_W'((SUM_W'(cur) + 1'b1) << HDR_SHIFT);
        state_next       = ST_DONE;
      end

      ST_F_INS1: begin
        link_we    = 1'b1;
        link_wa    = node;
        link_wd    = cur;
        state_next = ST_F_INS2;
      end

      ST_F_INS2: begin
        if (prev == NIL) begin
          head_next = IDX_W'(node);
        end else begin
          link_we = 1'b1;
          link_wa = prev[UNIT_W-1:0];
          link_wd = IDX_W'(node);
        end
        state_next = ST_F_RDN;
      end

      ST_F_RDN: begin
        rd_addr    = node;
        state_next = ST_F_CHKN;
      end

      ST_F_CHKN: begin
        node_size_next = rd_size;
        node_link_next = rd_link_c;
        rd_addr        = rd_link_c[UNIT_W-1:0];
        state_next     = ST_F_CHKN2;
      end

      ST_F_CHKN2: begin
        if (node_link != NIL &&
            node_end == (SUM_W'(node_link) << HDR_SHIFT)) begin
          size_we        = 1'b1;
          size_wa        = node;
          size_wd        = node_size + SIZE_W'(HEADER_BYTES) + rd_size;
          link_we        = 1'b1;
          link_wa        = node;
          link_wd        = rd_link_c;
          node_size_next = node_size + SIZE_W'(HEADER_BYTES) + rd_size;
          node_link_next = rd_link_c;
        end
        state_next = ST_F_RDP;
      end

      ST_F_RDP: begin
        rd_addr    = prev[UNIT_W-1:0];
        state_next = ST_F_CHKP;
      end

      ST_F_CHKP: begin
        if (prev != NIL && prev_end == (SUM_W'(node) << HDR_SHIFT)) begin
          size_we = 1'b1;
          size_wa = prev[UNIT_W-1:0];
          size_wd = rd_size + SIZE_W'(HEADER_BYTES) + node_size;
          link_we = 1'b1;
          link_wa = prev[UNIT_W-1:0];
          link_wd = node_link;
        end
        res_granted_next = 1'b1;
        res_offset_next  = '0;
        state_next       = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ffa_checker.sv =====
// ============================================================================
// First-fit free-list allocator checker
// Port-level properties of the allocator, attached to the allocator unit by bind.
// ============================================================================
`default_nettype none

module ffa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       granted,
  input wire logic [9:0] block_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(block_offset))
    else $error("Result item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again while an item is in work.");

  a_refused_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> block_offset == 10'd0)
    else $error("Refused item carries a nonzero offset.");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> block_offset[3:0] == 4'd0)
    else $error("Payload offset is not on a header boundary.");

endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .granted      (granted),
  .block_offset (block_offset)
);

`default_nettype wire

// ===== bench/tb_first_fit_free_list_allocator_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// First-fit free-list allocator unit testbench
// Drives allocate and free items through the valid/ready input channel and
// checks every result against an in-bench copy of the free list, with split
// and coalescing, updated as each item is accepted. Directed items cover the
// corner cases; random items keep a set of live blocks to free. The random
// part runs under several sender and receiver pacing patterns and includes
// one long receiver hold-off and one full drain.
// ============================================================================

module tb_first_fit_free_list_allocator_unit;

  import ffa_pkg::*;

  localparam int unsigned HDR      = HEADER_BYTES;
  localparam int unsigned NIL_UNIT = UNITS;
  localparam int          RANDOM_ITEMS = 1730;
  localparam int          HOLD_CYCLES  = 400;

  typedef struct packed {
    logic              action;
    logic [REQ_W-1:0]  request_size;
    logic [LG_W-1:0]   align_log2;
    logic [OFF_W-1:0]  free_offset;
  } request_t;

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] block_offset;
  } grant_t;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = ACT_ALLOC;
  logic [REQ_W-1:0] request_size = '0;
  logic [LG_W-1:0]  align_log2 = '0;
  logic [OFF_W-1:0] free_offset = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             granted;
  logic [OFF_W-1:0] block_offset;

  request_t         pending_requests[$];
  grant_t           awaited_grants[$];
  logic [OFF_W-1:0] live_offsets[$];

  logic [SIZE_W-1:0] model_size [UNITS];
  logic [IDX_W-1:0]  model_next [UNITS];
  bit                header_written [UNITS];
  int unsigned       model_head;

  pace_t idle_mode = PACE_FULL;
  int    items_queued = 0;
  int    results_seen = 0;
  int    mismatch_count = 0;
  int    hold_requests = 0;
  int    hold_served = 0;
  int    hold_left = 0;

  first_fit_free_list_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .request_size(request_size),
    .align_log2(align_log2),
    .free_offset(free_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .granted(granted),
    .block_offset(block_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned link_at(int unsigned u);
    int unsigned n;
    if (u >= NIL_UNIT) return NIL_UNIT;
    n = model_next[u];
    return (n >= NIL_UNIT) ? NIL_UNIT : n;
  endfunction

  function automatic int unsigned size_at(int unsigned u);
    return (u < NIL_UNIT) ? int'(model_size[u]) : 0;
  endfunction

  function automatic void put_next(int unsigned u, int unsigned to);
    if (u < NIL_UNIT) model_next[u] = IDX_W'(to);
  endfunction

  function automatic void put_size(int unsigned u, int unsigned sz);
    if (u < NIL_UNIT) begin
      model_size[u] = SIZE_W'(sz);
      header_written[u] = 1'b1;
    end
  endfunction

  function automatic grant_t predict_allocate(int unsigned req, int unsigned lg);
    grant_t      res;
    int unsigned align, pad, wanted, prev, cur, steps, csize, after, stride, split_unit;
    res = '0;
    align = 1 << lg;
    if (align < HDR) align = HDR;
    pad = (32'd0 - (HDR + req)) & (align - 1);
    if (pad > HDR) return res;
    wanted = req + pad;
    prev = NIL_UNIT;
    steps = 0;
    cur = (model_head >= NIL_UNIT) ? NIL_UNIT : model_head;
    while (cur != NIL_UNIT && wanted > size_at(cur)) begin
      steps++;
      if (steps >= NIL_UNIT) begin
        cur = NIL_UNIT;
        break;
      end
      prev = cur;
      cur = link_at(cur);
    end
    if (cur == NIL_UNIT) return res;
    csize = size_at(cur);
    after = link_at(cur);
    if (csize >= wanted + HDR + 1) begin
      stride = HDR + wanted;
      split_unit = cur + stride / HDR;
      if (split_unit < NIL_UNIT) begin
        put_size(split_unit, csize - stride);
        put_next(split_unit, after);
        after = split_unit;
      end else begin
        wanted = csize;
      end
    end else begin
      wanted = csize;
    end
    if (prev == NIL_UNIT) model_head = after;
    else put_next(prev, after);
    put_size(cur, wanted);
    res.granted = 1'b1;
    res.block_offset = OFF_W'((cur + 1) * HDR);
    live_offsets = {live_offsets, res.block_offset};
    return res;
  endfunction

  function automatic grant_t predict_release(int unsigned off);
    grant_t      res;
    int unsigned node, prev, cur, steps, nxt;
    res = '0;
    if (off < HDR || off % HDR != 0) return res;
    node = off / HDR - 1;
    if (node >= NIL_UNIT) return res;
    prev = NIL_UNIT;
    steps = 0;
    cur = (model_head >= NIL_UNIT) ? NIL_UNIT : model_head;
    while (cur != NIL_UNIT) begin
      if (node < cur) begin
        put_next(node, cur);
        if (prev == NIL_UNIT) model_head = node;
        else put_next(prev, node);
        break;
      end
      steps++;
      if (steps >= NIL_UNIT) begin
        cur = NIL_UNIT;
        break;
      end
      prev = cur;
      cur = link_at(cur);
    end
    if (cur == NIL_UNIT) begin
      put_next(node, NIL_UNIT);
      if (prev == NIL_UNIT) model_head = node;
      else put_next(prev, node);
    end
    nxt = link_at(node);
    if (nxt != NIL_UNIT && node * HDR + HDR + size_at(node) == nxt * HDR) begin
      put_size(node, size_at(node) + HDR + size_at(nxt));
      put_next(node, link_at(nxt));
    end
    if (prev != NIL_UNIT && prev * HDR + HDR + size_at(prev) == node * HDR) begin
      put_size(prev, size_at(prev) + HDR + size_at(node));
      put_next(prev, link_at(node));
    end
    res.granted = 1'b1;
    return res;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_mode)
      PACE_SENDER_IDLE: return 81;
      PACE_BOTH:        return 6;
      default:          return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      PACE_RECEIVER_STALL: return 81;
      PACE_BOTH:           return 6;
      default:             return 0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input grant_t want, input grant_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected granted=%0b offset=%0d, got granted=%0b offset=%0d",
               what, want.granted, want.block_offset, got.granted, got.block_offset);
  endtask

  task automatic offer(input logic act, input int unsigned sz, input int unsigned lg,
                       input int unsigned off);
    request_t req;
    req.action = act;
    req.request_size = (act == ACT_ALLOC) ? REQ_W'(sz) : REQ_W'($urandom_range(1023));
    req.align_log2 = (act == ACT_ALLOC) ? LG_W'(lg) : LG_W'($urandom_range(6));
    req.free_offset = (act == ACT_FREE) ? OFF_W'(off) : OFF_W'($urandom_range(1023));
    while (pending_requests.size() != 0) @(negedge clk);
    pending_requests = {pending_requests, req};
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk);
  endtask

  task automatic offer_random(input bit allow_broken);
    int          r, idx;
    int unsigned u, off;
    r = $urandom_range(99);
    if (allow_broken && r < 8) begin
      do u = $urandom_range(NIL_UNIT - 1); while (!header_written[u]);
      offer(ACT_FREE, 0, 0, (u + 1) * HDR);
    end else if (r < 12) begin
      off = $urandom_range(1023);
      if (off[3:0] == 4'd0) off = off & ~32'hFFF0;
      offer(ACT_FREE, 0, 0, off);
    end else if (live_offsets.size() != 0 && (live_offsets.size() > 6 || r[0])) begin
      idx = $urandom_range(live_offsets.size() - 1);
      off = live_offsets[idx];
      live_offsets.delete(idx);
      offer(ACT_FREE, 0, 0, off);
    end else if (r < 22) begin
      offer(ACT_ALLOC, $urandom_range(1023), $urandom_range(6), 0);
    end else begin
      offer(ACT_ALLOC, $urandom_range(160), $urandom_range(6), 0);
    end
  endtask

  // Sender: the accepted item updates the free list copy before the next is offered.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (action == ACT_ALLOC)
          awaited_grants = {awaited_grants, predict_allocate(request_size, align_log2)};
        else
          awaited_grants = {awaited_grants, predict_release(free_offset)};
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          {action, request_size, align_log2, free_offset} <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    grant_t got;
    got = {granted, block_offset};
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited_grants.size() == 0) note_mismatch("no item expected", '0, got);
      else if (got !== awaited_grants[0]) note_mismatch("result", awaited_grants[0], got);
      if (awaited_grants.size() != 0) void'(awaited_grants.pop_front());
    end
  end

  initial begin
    for (int u = 0; u < UNITS; u++) begin
      model_size[u] = '0;
      model_next[u] = '0;
      header_written[u] = 1'b0;
    end
    model_head = 0;
    put_size(0, ARENA_BYTES - HEADER_BYTES);
    put_next(0, NIL_UNIT);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer(ACT_ALLOC, 0, 0, 0);
    offer(ACT_ALLOC, 1023, 0, 0);
    offer(ACT_ALLOC, 1, 6, 0);
    offer(ACT_ALLOC, 48, 6, 0);
    offer(ACT_ALLOC, 40, 5, 0);
    offer(ACT_ALLOC, 100, 4, 0);
    offer(ACT_FREE, 0, 0, 32);
    offer(ACT_FREE, 0, 0, 96);
    offer(ACT_FREE, 0, 0, 16);
    offer(ACT_FREE, 0, 0, 160);
    offer(ACT_ALLOC, 992, 0, 0);
    offer(ACT_ALLOC, 0, 0, 0);
    offer(ACT_FREE, 0, 0, 16);
    offer(ACT_ALLOC, 1008, 2, 0);
    offer(ACT_FREE, 0, 0, 16);
    offer(ACT_FREE, 0, 0, 0);
    offer(ACT_FREE, 0, 0, 8);
    offer(ACT_FREE, 0, 0, 1023);
    offer(ACT_ALLOC, 1007, 6, 0);
    offer(ACT_FREE, 0, 0, 16);
    offer(ACT_ALLOC, 1023, 3, 0);
    wait_drained();
    live_offsets.delete();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= 480 && i < 600) idle_mode = PACE_FULL;
      else idle_mode = pace_t'((i / 160) % 4);
      if (i == 500) hold_requests++;
      if (i == 1000) begin
        wait_drained();
        repeat ($urandom_range(5, 40)) @(negedge clk);
      end
      offer_random(i >= RANDOM_ITEMS - 150);
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (mismatch_count == 0 && awaited_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
